[design/assert_macros.svh]
// Assertion helper macros shared by the tone control RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true while out of reset
`define BFO_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define BFO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[design/bfo_mdtc_pkg.sv]
// Package for the metal detector tone control block.
// Holds payload types, register codes and fixed constants; no dependencies.
package bfo_mdtc_pkg;

    // Width of the measurement count field
    localparam int CNT_W = 24;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_THRESH_MIN   = 3'd0,
        CFG_THRESH_MAX   = 3'd1,
        CFG_HB_PERIOD    = 3'd2,
        CFG_BEEP_DIVIDER = 3'd3,
        CFG_TONE_MAX     = 3'd4
    } cfg_reg_t;

    // Register reset values
    localparam logic [7:0] THRESH_MIN_RST   = 8'd2;
    localparam logic [7:0] THRESH_MAX_RST   = 8'd30;
    localparam logic [7:0] HB_PERIOD_RST    = 8'd150;
    localparam logic [6:0] BEEP_DIVIDER_RST = 7'd20;
    localparam logic [6:0] TONE_MAX_RST     = 7'd100;

    // Offset added to diff/4 for the detection tone divider
    localparam logic [22:0] TONE_OFFSET = 23'd10;

    // One measurement request
    typedef struct packed {
        logic [CNT_W-1:0] measurement_count;
        logic             button_calibrate;
        logic             button_plus;
        logic             button_minus;
    } meas_item_t;

    // One result
    typedef struct packed {
        logic       tone_on;
        logic [6:0] tone_divider;
        logic       fault;
        logic       calibrating;
        logic [7:0] detect_level;
    } result_item_t;

endpackage

[design/bfo_mdtc_stream_if.sv]
// Valid/ready stream interface used for measurement and result channels.
// Payload type is a parameter; no other dependencies.
interface bfo_mdtc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/bfo_metal_detect_tone_control_unit.sv]
// An accepted request is held in the input register, its result in the result register; the two
// keep both sides moving, for one request per cycle unless result.ready is low or div_busy is set.
// When CAL_SAMPLES is not a power of two, the baseline comes from a reciprocal multiply in
// the cycle after the last calibration request; no request advances during that multiply.
// Reset (rst_n, async, active low) starts a calibration and loads register defaults.
// Depends on bfo_mdtc_pkg, bfo_mdtc_stream_if and assert_macros.svh.
`include "assert_macros.svh"

module bfo_metal_detect_tone_control_unit #(
    parameter int CAL_SAMPLES = 8,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [2:0]                   cfg_index,
    input  logic [7:0]                   cfg_data,
    bfo_mdtc_stream_if.sink              meas,
    bfo_mdtc_stream_if.source            result
);

    localparam int CW    = (COUNT_WIDTH < bfo_mdtc_pkg::CNT_W) ? COUNT_WIDTH
                                                                : bfo_mdtc_pkg::CNT_W;
    localparam logic [bfo_mdtc_pkg::CNT_W-1:0] CNT_MASK =
        bfo_mdtc_pkg::CNT_W'((33'd1 << CW) - 33'd1);
    localparam int LOG   = $clog2(CAL_SAMPLES);
    localparam int SW    = bfo_mdtc_pkg::CNT_W + LOG;
    localparam int IW    = $clog2(CAL_SAMPLES + 1);
    localparam bit POW2  = ((CAL_SAMPLES & (CAL_SAMPLES - 1)) == 0);

    // Configuration registers
    logic [7:0] thresh_min_reg, thresh_max_reg, hb_period_reg;
    logic [6:0] beep_div_reg, tone_max_reg;

    // Block state
    logic [bfo_mdtc_pkg::CNT_W-1:0] baseline_reg;
    logic [SW-1:0] cal_sum_reg, cal_sum_next;
    logic [IW-1:0] cal_idx_reg, cal_idx_next;
    logic          cal_active_reg, cal_active_next;
    logic [7:0]    thresh_reg, thresh_next;
    logic          err_reg, err_next;
    logic          above_reg, above_next;
    logic          beat_reg, beat_next;
    logic [7:0]    beat_cnt_reg, beat_cnt_next;
    logic          tone_act_reg, tone_act_next;
    logic [6:0]    tone_val_reg, tone_val_next;

    // Input stage and result stage
    logic                       stg_vld_reg;
    bfo_mdtc_pkg::meas_item_t   stg_reg;
    logic                       res_vld_reg;
    bfo_mdtc_pkg::result_item_t res_reg;

    logic                           advance;
    logic                           div_busy;
    logic                           cal_done;
    logic                           base_load;
    logic [bfo_mdtc_pkg::CNT_W-1:0] base_value;
    logic [bfo_mdtc_pkg::CNT_W-1:0] count;
    logic [bfo_mdtc_pkg::CNT_W-1:0] diff;
    logic [22:0]                    div_full;
    logic [6:0]                     div_sat;
    logic [IW-1:0]                  idx_inc;
    logic                           cal_last;
    logic [SW-1:0]                  cal_total;

    // Handshake: stage moves on when the result slot is free or being drained and no divide is busy
    assign advance      = stg_vld_reg && !div_busy && (!res_vld_reg || result.ready);
    assign meas.ready   = !stg_vld_reg || advance;
    assign result.valid = res_vld_reg;
    assign result.data  = res_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_min_reg <= bfo_mdtc_pkg::THRESH_MIN_RST;
            thresh_max_reg <= bfo_mdtc_pkg::THRESH_MAX_RST;
            hb_period_reg  <= bfo_mdtc_pkg::HB_PERIOD_RST;
            beep_div_reg   <= bfo_mdtc_pkg::BEEP_DIVIDER_RST;
            tone_max_reg   <= bfo_mdtc_pkg::TONE_MAX_RST;
        end
        else if (cfg_write)
        begin
            unique case (bfo_mdtc_pkg::cfg_reg_t'(cfg_index))
                bfo_mdtc_pkg::CFG_THRESH_MIN:   thresh_min_reg <= cfg_data;
                bfo_mdtc_pkg::CFG_THRESH_MAX:   thresh_max_reg <= cfg_data;
                bfo_mdtc_pkg::CFG_HB_PERIOD:    hb_period_reg  <= cfg_data;
                bfo_mdtc_pkg::CFG_BEEP_DIVIDER: beep_div_reg   <= cfg_data[6:0];
                bfo_mdtc_pkg::CFG_TONE_MAX:     tone_max_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Datapath terms for the staged request
    assign count     = stg_reg.measurement_count & CNT_MASK;
    assign diff      = (count > baseline_reg) ? count - baseline_reg : baseline_reg - count;
    assign div_full  = 23'(diff[bfo_mdtc_pkg::CNT_W-1:2]) + bfo_mdtc_pkg::TONE_OFFSET;
    assign div_sat   = (div_full >= 23'(tone_max_reg)) ? tone_max_reg : div_full[6:0];
    assign idx_inc   = cal_idx_reg + IW'(1);
    assign cal_last  = (idx_inc >= IW'(CAL_SAMPLES));
    assign cal_done  = advance && cal_active_reg && cal_last;
    assign cal_total = cal_sum_reg + SW'(count);

    // Next state for one request
    always_comb
    begin
        cal_sum_next    = cal_sum_reg;
        cal_idx_next    = cal_idx_reg;
        cal_active_next = cal_active_reg;
        thresh_next     = thresh_reg;
        err_next        = err_reg;
        above_next      = above_reg;
        beat_next       = beat_reg;
        beat_cnt_next   = beat_cnt_reg;
        tone_act_next   = tone_act_reg;
        tone_val_next   = tone_val_reg;

        if (cal_active_reg)
        begin
            // Accumulate calibration sample
            cal_sum_next = cal_total;
            cal_idx_next = idx_inc;
            if (cal_last)
            begin
                cal_sum_next    = '0;
                cal_idx_next    = '0;
                cal_active_next = 1'b0;
                thresh_next     = thresh_min_reg;
            end
        end
        else if (count == '0)
        begin
            // Enter coil fault mode
            if (!err_reg)
            begin
                tone_act_next = 1'b1;
                tone_val_next = beep_div_reg;
                err_next      = 1'b1;
                above_next    = 1'b0;
                beat_next     = 1'b0;
            end
        end
        else
        begin
            // Leave fault mode
            if (err_reg)
            begin
                tone_act_next = 1'b0;
                err_next      = 1'b0;
                above_next    = 1'b0;
                beat_next     = 1'b0;
            end

            // Detection against threshold
            if (diff < bfo_mdtc_pkg::CNT_W'(thresh_reg))
            begin
                if (above_next)
                begin
                    tone_act_next = 1'b0;
                    above_next    = 1'b0;
                end
            end
            else
            begin
                if (!above_next)
                begin
                    tone_act_next = 1'b1;
                    tone_val_next = div_sat;
                    above_next    = 1'b1;
                end
                else if (tone_val_next != div_sat)
                begin
                    tone_act_next = 1'b1;
                    tone_val_next = div_sat;
                end
            end

            // Buttons: calibrate over plus over minus
            if (stg_reg.button_calibrate)
            begin
                cal_active_next = 1'b1;
                cal_idx_next    = '0;
                cal_sum_next    = '0;
            end
            else if (stg_reg.button_plus)
            begin
                if (thresh_reg < thresh_max_reg)
                    thresh_next = thresh_reg + 8'd1;
            end
            else if (stg_reg.button_minus)
            begin
                if (thresh_reg > thresh_min_reg)
                    thresh_next = thresh_reg - 8'd1;
            end

            // Heartbeat beep
            if (beat_next)
            begin
                if (!above_next)
                    tone_act_next = 1'b0;
                beat_next = 1'b0;
            end
            else if (beat_cnt_reg == hb_period_reg)
            begin
                beat_next = 1'b1;
                if (!above_next)
                begin
                    tone_act_next = 1'b1;
                    tone_val_next = beep_div_reg;
                end
                beat_cnt_next = '0;
            end
            else
            begin
                beat_cnt_next = beat_cnt_reg + 8'd1;
            end
        end
    end

    // Baseline from the calibration sum
    generate
        if (POW2)
        begin : g_shift
            assign div_busy   = 1'b0;
            assign base_load  = cal_done;
            assign base_value = cal_total[LOG +: bfo_mdtc_pkg::CNT_W];
        end
        else
        begin : g_recip
            // floor(sum / CAL_SAMPLES) as (sum * RECIP) >> RSH, exact for any SW-bit sum
            localparam int RSH = SW + LOG;
            localparam int MW  = SW + 1;
            localparam int PW  = SW + MW;
            localparam logic [MW-1:0] RECIP =
                MW'(((64'd1 << RSH) + 64'(CAL_SAMPLES - 1)) / 64'(CAL_SAMPLES));

            logic          busy_reg;
            logic [SW-1:0] sum_reg;
            logic [PW-1:0] prod;

            assign prod       = PW'(sum_reg) * PW'(RECIP);
            assign div_busy   = busy_reg;
            assign base_load  = busy_reg;
            assign base_value = prod[RSH +: bfo_mdtc_pkg::CNT_W];

            // Hold requests while the multiply runs
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    busy_reg <= 1'b0;
                else
                    busy_reg <= cal_done;
            end

            // Capture the final calibration sum
            always_ff @(posedge clk)
            begin
                if (cal_done)
                    sum_reg <= cal_total;
            end
        end
    endgenerate

    // Hold baseline until a calibration completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            baseline_reg <= '0;
        else if (base_load)
            baseline_reg <= base_value;
    end

    // Advance block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_sum_reg    <= '0;
            cal_idx_reg    <= '0;
            cal_active_reg <= 1'b1;
            thresh_reg     <= bfo_mdtc_pkg::THRESH_MIN_RST;
            err_reg        <= 1'b0;
            above_reg      <= 1'b0;
            beat_reg       <= 1'b0;
            beat_cnt_reg   <= '0;
            tone_act_reg   <= 1'b0;
            tone_val_reg   <= '0;
        end
        else if (advance)
        begin
            cal_sum_reg    <= cal_sum_next;
            cal_idx_reg    <= cal_idx_next;
            cal_active_reg <= cal_active_next;
            thresh_reg     <= thresh_next;
            err_reg        <= err_next;
            above_reg      <= above_next;
            beat_reg       <= beat_next;
            beat_cnt_reg   <= beat_cnt_next;
            tone_act_reg   <= tone_act_next;
            tone_val_reg   <= tone_val_next;
        end
    end

    // Input stage valid and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (meas.ready)
                stg_vld_reg <= meas.valid;
            if (advance)
                res_vld_reg <= 1'b1;
            else if (result.ready)
                res_vld_reg <= 1'b0;
        end
    end

    // Capture request and result payloads
    always_ff @(posedge clk)
    begin
        if (meas.valid && meas.ready)
            stg_reg <= meas.data;
        if (advance)
        begin
            res_reg.tone_on      <= tone_act_next;
            res_reg.tone_divider <= tone_val_next;
            res_reg.fault        <= err_next;
            res_reg.calibrating  <= cal_active_next;
            res_reg.detect_level <= thresh_next;
        end
    end

    `BFO_ASSERT_NEVER(a_fault_not_cal, err_reg && cal_active_reg, "fault during calibration")
    `BFO_ASSERT_IMP(a_above_tone, above_reg, tone_act_reg, "detection without tone")
    `BFO_ASSERT_NEVER(a_beat_not_fault, beat_reg && err_reg, "heartbeat flag in fault mode")
    `BFO_ASSERT_IMP(a_div_stall, div_busy, !advance, "request advanced during baseline divide")

endmodule

[bench/testbench.sv]
// Self-checking bench for the metal detector tone control unit.
// Depends on bfo_mdtc_pkg, bfo_mdtc_stream_if and the unit's top module.
`timescale 1ns / 1ps

// Tracks the tone control state per accepted request and checks each result
class tone_scoreboard;
    localparam int CAL_N = 8;

    // register copies
    logic [7:0] thresh_min;
    logic [7:0] thresh_max;
    logic [7:0] hb_period;
    logic [6:0] beep_div;
    logic [6:0] tone_max;

    // block state
    logic [bfo_mdtc_pkg::CNT_W-1:0] baseline;
    logic [26:0]      cal_sum;
    int               cal_index;
    bit               cal_active;
    logic [7:0]       threshold;
    bit               fault_mode;
    bit               above;
    bit               beat;
    logic [7:0]       beat_count;
    bit               tone_active;
    logic [6:0]       tone_value;

    bfo_mdtc_pkg::result_item_t predicted_results[$];
    int mismatches;
    int checked;
    int fault_entries;
    int heartbeats;

    function new();
        thresh_min  = bfo_mdtc_pkg::THRESH_MIN_RST;
        thresh_max  = bfo_mdtc_pkg::THRESH_MAX_RST;
        hb_period   = bfo_mdtc_pkg::HB_PERIOD_RST;
        beep_div    = bfo_mdtc_pkg::BEEP_DIVIDER_RST;
        tone_max    = bfo_mdtc_pkg::TONE_MAX_RST;
        baseline    = '0;
        cal_sum     = '0;
        cal_index   = 0;
        cal_active  = 1'b1;
        threshold   = bfo_mdtc_pkg::THRESH_MIN_RST;
        fault_mode  = 1'b0;
        above       = 1'b0;
        beat        = 1'b0;
        beat_count  = '0;
        tone_active = 1'b0;
        tone_value  = '0;
        mismatches  = 0;
        checked     = 0;
        fault_entries = 0;
        heartbeats  = 0;
    endfunction

    function void set_reg(bfo_mdtc_pkg::cfg_reg_t idx, logic [7:0] val);
        case (idx)
            bfo_mdtc_pkg::CFG_THRESH_MIN:   thresh_min = val;
            bfo_mdtc_pkg::CFG_THRESH_MAX:   thresh_max = val;
            bfo_mdtc_pkg::CFG_HB_PERIOD:    hb_period  = val;
            bfo_mdtc_pkg::CFG_BEEP_DIVIDER: beep_div   = val[6:0];
            bfo_mdtc_pkg::CFG_TONE_MAX:     tone_max   = val[6:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return predicted_results.size();
    endfunction

    // Advance the state by one accepted request and queue the expected result
    function void note_request(bfo_mdtc_pkg::meas_item_t req);
        logic [bfo_mdtc_pkg::CNT_W-1:0] cnt;
        logic [bfo_mdtc_pkg::CNT_W-1:0] diff;
        int unsigned                    div;
        bfo_mdtc_pkg::result_item_t     want;
        cnt = req.measurement_count;
        if (cal_active) begin
            // accumulate a baseline sample, buttons ignored
            cal_sum = cal_sum + 27'(cnt);
            cal_index++;
            if (cal_index >= CAL_N) begin
                baseline   = bfo_mdtc_pkg::CNT_W'(cal_sum / CAL_N);
                cal_sum    = '0;
                cal_index  = 0;
                cal_active = 1'b0;
                threshold  = thresh_min;
            end
        end else if (cnt == '0) begin
            // coil fault: beep once on entry, skip everything else
            if (!fault_mode) begin
                tone_active = 1'b1;
                tone_value  = beep_div;
                fault_mode  = 1'b1;
                above       = 1'b0;
                beat        = 1'b0;
                fault_entries++;
            end
        end else begin
            if (fault_mode) begin
                tone_active = 1'b0;
                fault_mode  = 1'b0;
                above       = 1'b0;
                beat        = 1'b0;
            end
            // detection against the baseline
            diff = (cnt > baseline) ? cnt - baseline : baseline - cnt;
            if (diff < bfo_mdtc_pkg::CNT_W'(threshold)) begin
                if (above) begin
                    tone_active = 1'b0;
                    above       = 1'b0;
                end
            end else begin
                div = 32'(diff) / 32'd4 + 32'd10;
                if (div >= 32'(tone_max))
                    div = 32'(tone_max);
                if (!above) begin
                    tone_active = 1'b1;
                    tone_value  = div[6:0];
                    above       = 1'b1;
                end else if (tone_value != div[6:0]) begin
                    tone_active = 1'b1;
                    tone_value  = div[6:0];
                end
            end
            // buttons: calibrate over plus over minus
            if (req.button_calibrate) begin
                cal_active = 1'b1;
                cal_index  = 0;
                cal_sum    = '0;
            end else if (req.button_plus) begin
                if (threshold < thresh_max)
                    threshold = threshold + 8'd1;
            end else if (req.button_minus) begin
                if (threshold > thresh_min)
                    threshold = threshold - 8'd1;
            end
            // heartbeat
            if (beat) begin
                if (!above)
                    tone_active = 1'b0;
                beat = 1'b0;
            end else if (beat_count == hb_period) begin
                beat = 1'b1;
                if (!above) begin
                    tone_active = 1'b1;
                    tone_value  = beep_div;
                end
                beat_count = '0;
                heartbeats++;
            end else begin
                beat_count = beat_count + 8'd1;
            end
        end
        want.tone_on      = tone_active;
        want.tone_divider = tone_value;
        want.fault        = fault_mode;
        want.calibrating  = cal_active;
        want.detect_level = threshold;
        predicted_results.push_back(want);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(bfo_mdtc_pkg::result_item_t got);
        bfo_mdtc_pkg::result_item_t want;
        if (predicted_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result with no request pending:", $time,
                         " on=%0d div=%0d flt=%0d cal=%0d lvl=%0d",
                         got.tone_on, got.tone_divider, got.fault, got.calibrating,
                         got.detect_level);
            return;
        end
        want = predicted_results.pop_front();
        checked++;
        if (got.tone_on !== want.tone_on || got.tone_divider !== want.tone_divider ||
            got.fault !== want.fault || got.calibrating !== want.calibrating ||
            got.detect_level !== want.detect_level) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result %0d:", $time, checked,
                         " exp on=%0d div=%0d flt=%0d cal=%0d lvl=%0d,",
                         want.tone_on, want.tone_divider, want.fault,
                         want.calibrating, want.detect_level,
                         " got on=%0d div=%0d flt=%0d cal=%0d lvl=%0d",
                         got.tone_on, got.tone_divider,
                         got.fault, got.calibrating, got.detect_level);
        end
    endfunction
endclass

module testbench;
    localparam int CAL_N        = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int BLOCK_ITEMS  = 275;
    localparam int CW           = bfo_mdtc_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    bfo_mdtc_stream_if #(.payload_t(bfo_mdtc_pkg::meas_item_t))   meas_if ();
    bfo_mdtc_stream_if #(.payload_t(bfo_mdtc_pkg::result_item_t)) res_if ();

    bfo_metal_detect_tone_control_unit #(
        .CAL_SAMPLES (CAL_N),
        .COUNT_WIDTH (CW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas_if),
        .result    (res_if)
    );

    tone_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int requests_sent;
    int settings_used;
    int cycle_count;

    // stimulus-side view of calibration and baseline
    int gen_center;
    int gen_cal_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Monitor both channels on pre-edge values
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (meas_if.valid && meas_if.ready)
                sb.note_request(meas_if.data);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.data);
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request != 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (rst_n !== 1'b1)
                res_if.ready <= 1'b0;
            else if (stall_left != 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
        end
    end

    function automatic logic [CW-1:0] clamp_count(int v);
        if (v < 1)
            return CW'(1);
        if (v > int'(CNT_MAX))
            return CNT_MAX;
        return v[CW-1:0];
    endfunction

    // Offer one request, idling per cycle first; return at acceptance
    task automatic send_request(bfo_mdtc_pkg::meas_item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            meas_if.valid <= 1'b0;
            @(posedge clk);
        end
        meas_if.valid <= 1'b1;
        meas_if.data  <= req;
        do
            @(posedge clk);
        while (!meas_if.ready);
        requests_sent++;
    endtask

    task automatic send_fields(logic [CW-1:0] cnt, bit cal, bit plus, bit minus);
        bfo_mdtc_pkg::meas_item_t req;
        req.measurement_count = cnt;
        req.button_calibrate  = cal;
        req.button_plus       = plus;
        req.button_minus      = minus;
        send_request(req);
    endtask

    // Drop valid and wait until every result is back, then a few more cycles
    task automatic wait_idle();
        meas_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(bfo_mdtc_pkg::cfg_reg_t idx, logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic program_regs(logic [7:0] tmin, logic [7:0] tmax, logic [7:0] period,
                                logic [7:0] beep, logic [7:0] tone_lim);
        write_reg(bfo_mdtc_pkg::CFG_THRESH_MIN, tmin);
        write_reg(bfo_mdtc_pkg::CFG_THRESH_MAX, tmax);
        write_reg(bfo_mdtc_pkg::CFG_HB_PERIOD, period);
        write_reg(bfo_mdtc_pkg::CFG_BEEP_DIVIDER, beep);
        write_reg(bfo_mdtc_pkg::CFG_TONE_MAX, tone_lim);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Main sequence
    initial
    begin
        int blk;
        int n;
        int r;
        int mag;
        bfo_mdtc_pkg::meas_item_t req;

        sb = new();
        hold_request  = 0;
        requests_sent = 0;
        settings_used = 0;
        send_idle_pct = 16;
        recv_idle_pct = 82;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= bfo_mdtc_pkg::CFG_THRESH_MIN;
        cfg_data  <= '0;
        meas_if.valid <= 1'b0;
        meas_if.data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: calibrate to full scale after reset, register defaults
        repeat (CAL_N) send_fields(CNT_MAX, 1'b1, 1'b1, 1'b1);
        // huge difference saturates the divider; plus beats minus
        send_fields(CW'(1), 1'b0, 1'b1, 1'b1);
        // coil fault entry, then held
        send_fields('0, 1'b0, 1'b1, 1'b0);
        send_fields('0, 1'b1, 1'b0, 1'b1);
        // leave fault on a count equal to the baseline
        send_fields(CNT_MAX, 1'b0, 1'b0, 1'b1);
        // difference exactly at the threshold, then just below
        send_fields(CNT_MAX - CW'(2), 1'b0, 1'b0, 1'b0);
        send_fields(CNT_MAX - CW'(1), 1'b0, 1'b0, 1'b0);
        // calibrate wins over both threshold buttons
        send_fields(CNT_MAX - CW'(41), 1'b1, 1'b1, 1'b1);
        // calibration with zero samples and pressed buttons
        send_fields('0, 1'b1, 1'b0, 1'b0);
        send_fields('0, 1'b0, 1'b1, 1'b0);
        send_fields(CW'(5), 1'b0, 1'b0, 1'b1);
        send_fields(CW'(1000), 1'b1, 1'b1, 1'b1);
        send_fields('0, 1'b0, 1'b0, 1'b0);
        send_fields(CW'(7), 1'b1, 1'b0, 1'b0);
        send_fields(CW'(3), 1'b0, 1'b1, 1'b1);
        send_fields(CW'(1), 1'b0, 1'b0, 1'b0);
        send_fields(CW'(527), 1'b0, 1'b0, 1'b0);
        send_fields(CW'(127), 1'b0, 1'b0, 1'b0);
        gen_center   = 127;
        gen_cal_left = 0;

        // Random blocks, one register setting each
        for (blk = 0; blk < 6; blk++)
        begin
            wait_idle();
            if (blk < 2)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 82;
            end
            else if (blk < 4)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (blk)
                0: program_regs(bfo_mdtc_pkg::THRESH_MIN_RST, bfo_mdtc_pkg::THRESH_MAX_RST,
                                bfo_mdtc_pkg::HB_PERIOD_RST,
                                8'(bfo_mdtc_pkg::BEEP_DIVIDER_RST),
                                8'(bfo_mdtc_pkg::TONE_MAX_RST));
                1: program_regs(8'd0, 8'd255, 8'd1, 8'd1, 8'd127);
                2: program_regs(8'd255, 8'd0, 8'd255, 8'd127, 8'd1);
                3: program_regs(8'd5, 8'd12, 8'd7, 8'd63, 8'd40);
                4: program_regs(8'($urandom_range(0, 40)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(1, 255)), 8'($urandom_range(1, 127)),
                                8'($urandom_range(1, 127)));
                default: program_regs(8'd10, 8'd10, 8'd3, 8'd127, 8'd127);
            endcase
            // hold the receiver off while requests keep coming
            if (blk == 5)
                hold_request = 400;

            for (n = 0; n < BLOCK_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (gen_cal_left > 0)
                begin
                    // baseline sample close to the chosen center
                    if (r < 5)
                        req.measurement_count = '0;
                    else
                        req.measurement_count =
                            clamp_count(gen_center + int'($urandom_range(0, 6)) - 3);
                    req.button_calibrate = 1'($urandom_range(1));
                    req.button_plus      = 1'($urandom_range(1));
                    req.button_minus     = 1'($urandom_range(1));
                    gen_cal_left--;
                end
                else
                begin
                    if (r < 5)
                        req.measurement_count = '0;
                    else if (r < 10)
                        req.measurement_count = CW'($urandom);
                    else
                    begin
                        case ($urandom_range(2))
                            0: mag = $urandom_range(0, 40);
                            1: mag = $urandom_range(0, 600);
                            default: mag = $urandom_range(0, 4000);
                        endcase
                        if ($urandom_range(1))
                            mag = -mag;
                        req.measurement_count = clamp_count(gen_center + mag);
                    end
                    req.button_calibrate = ($urandom_range(99) < 3);
                    req.button_plus      = ($urandom_range(99) < 20);
                    req.button_minus     = ($urandom_range(99) < 20);
                    // a nonzero count with calibrate starts a new baseline
                    if (req.button_calibrate && req.measurement_count != '0)
                    begin
                        gen_cal_left = CAL_N;
                        case ($urandom_range(3))
                            0: gen_center = $urandom_range(1, 300);
                            1: gen_center = $urandom_range(1000, 100000);
                            2: gen_center = int'(CNT_MAX) - int'($urandom_range(0, 200));
                            default: gen_center = int'(CW'($urandom));
                        endcase
                    end
                end
                send_request(req);
            end
        end

        // Drain and report
        wait_idle();
        $display("Sent %0d requests under %0d register settings; %0d results checked,",
                 requests_sent, settings_used, sb.checked);
        $display("with %0d coil fault entries and %0d heartbeat beeps predicted.",
                 sb.fault_entries, sb.heartbeats);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
